// ----- hw/rtl/bos_pkg.sv -----
// Package for the batch order statistics block.
// Holds shared widths, default parameters and the chain control struct.
`default_nettype none
package bos_pkg;

  localparam int MAX_SAMPLES_DEF  = 32;
  localparam int SAMPLE_WIDTH_DEF = 24;
  // Result field widths
  localparam int OUT_W = 24;
  localparam int CNT_W = 6;
  // Width of the wrapped arithmetic
  localparam int ACC_W = 64;

  // Per-cycle command to the row of sorting cells
  typedef struct packed {
    logic ins;    // insert the incoming sample in sorted position
    logic shift;  // move every value one cell toward the head
    logic clr;    // mark every cell empty
  } bos_chain_ctrl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/batch_order_statistics_top.sv -----
// Top level of the batch order statistics block: handshake, sums, sequencer
// and the serial multiply, divide and square root units.
// Depends on bos_pkg and bos_chain.
//
// Samples enter one per cycle while in_ready is high and are placed in
// sorted order in a row of MAX_SAMPLES cells as they arrive; a running sum
// and sum of squares are kept alongside. After the last item of a batch,
// in_ready stays low while the block works out the result: it shifts the
// sorted row past the head (minimum, lower median, maximum), then runs a
// one-bit-per-cycle multiplier, takes the difference, runs a restoring
// divider and a two-bit-per-step square root, then hands the result to the
// output register. The result waits in its own register, so the next batch
// may load while it is not taken.
// Items past MAX_SAMPLES are dropped and flagged in out_overflow.
`default_nettype none
module batch_order_statistics_top #(
  parameter int MAX_SAMPLES  = bos_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_WIDTH = bos_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire [SAMPLE_WIDTH-1:0]      in_sample,
  input  wire                         in_last,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [bos_pkg::OUT_W-1:0]   out_minimum,
  output logic [bos_pkg::OUT_W-1:0]   out_median,
  output logic [bos_pkg::OUT_W-1:0]   out_maximum,
  output logic [bos_pkg::OUT_W-1:0]   out_mean,
  output logic [bos_pkg::OUT_W-1:0]   out_std_dev,
  output logic [bos_pkg::CNT_W-1:0]   out_count,
  output logic                        out_overflow
);
  import bos_pkg::*;

  localparam int CW      = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W   = (SAMPLE_WIDTH + CW > ACC_W) ? ACC_W : SAMPLE_WIDTH + CW;
  localparam int SQ_W    = (2*SAMPLE_WIDTH + CW > ACC_W) ? ACC_W : 2*SAMPLE_WIDTH + CW;
  localparam int NN_W    = 2*CW;
  localparam int STEP_W  = $clog2(ACC_W);
  localparam int CT_W    = (CW > STEP_W) ? CW : STEP_W;
  localparam int SQ_STEPS = ACC_W/2;

  typedef enum logic [7:0] {
    S_LOAD = 8'b0000_0001,
    S_SCAN = 8'b0000_0010,
    S_MULA = 8'b0000_0100,
    S_MULB = 8'b0000_1000,
    S_DIFF = 8'b0001_0000,
    S_DIVV = 8'b0010_0000,
    S_DIVM = 8'b0100_0000,
    S_SQRT = 8'b1000_0000
  } bos_state_t;

  bos_state_t state_r, state_nxt;
  logic                    done_r, done_nxt;   // result ready for output reg
  logic [CW-1:0]           kept_r, kept_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic                    drop_r, drop_nxt;
  logic [CT_W-1:0]         cnt_r, cnt_nxt;
  logic [ACC_W-1:0]        mc_r, mc_nxt, mp_r, mp_nxt, acc_r, acc_nxt, a_r, a_nxt;
  logic [ACC_W-1:0]        q_r, q_nxt, var_r, var_nxt;
  logic [NN_W-1:0]         rem_r, rem_nxt, div_r, div_nxt;
  logic [ACC_W-1:0]        x_r, x_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [SAMPLE_WIDTH-1:0] min_r, min_nxt, med_r, med_nxt, max_r, max_nxt;
  logic [ACC_W-1:0]        mean_r, mean_nxt;
  logic                    ov_r, ov_nxt;
  logic [CW-1:0]           n_r, n_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]        o_min_r, o_med_r, o_max_r, o_mean_r, o_std_r;
  logic [CNT_W-1:0]        o_cnt_r;
  logic                    o_ov_r;

  bos_chain_ctrl_t         ctrl;
  logic [SAMPLE_WIDTH-1:0] head_val;
  logic                    in_acc, keep, out_load;
  logic [2*SAMPLE_WIDTH-1:0] sq_prod;
  logic [NN_W-1:0]         nn;
  logic [CW-1:0]           med_idx;

  // Serial arithmetic step values
  logic [ACC_W-1:0]        mul_acc;
  logic [NN_W:0]           dv_t;
  logic                    dv_ge;
  logic [ACC_W-1:0]        dv_q;
  logic [NN_W-1:0]         dv_rem;
  logic [ACC_W:0]          sr_t;
  logic                    sr_ge;
  logic [ACC_W-1:0]        sr_x, sr_res;

  assign in_ready = (state_r == S_LOAD) && !done_r;
  assign in_acc   = in_valid && in_ready;
  assign keep     = kept_r < CW'(MAX_SAMPLES);
  assign sq_prod  = in_sample * in_sample;
  assign nn       = kept_r * kept_r;
  assign med_idx  = (kept_r - CW'(1)) >> 1;
  assign out_load = done_r && (!out_valid_r || out_ready);

  // Sorting row control
  always_comb begin
    ctrl.ins   = in_acc && keep;
    ctrl.shift = (state_r == S_SCAN);
    ctrl.clr   = out_load;
  end

  bos_chain #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .new_val  (in_sample),
    .head_val (head_val)
  );

  // One step of each serial unit
  always_comb begin
    mul_acc = acc_r + (mp_r[0] ? mc_r : '0);
    dv_t    = {rem_r, q_r[ACC_W-1]};
    dv_ge   = dv_t >= {1'b0, div_r};
    dv_rem  = dv_ge ? NN_W'(dv_t - {1'b0, div_r}) : NN_W'(dv_t);
    dv_q    = {q_r[ACC_W-2:0], dv_ge};
    sr_t    = {1'b0, res_r} + {1'b0, bit_r};
    sr_ge   = {1'b0, x_r} >= sr_t;
    sr_x    = sr_ge ? (x_r - sr_t[ACC_W-1:0]) : x_r;
    sr_res  = sr_ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    done_nxt      = done_r;
    kept_nxt      = kept_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    drop_nxt      = drop_r;
    cnt_nxt       = cnt_r;
    mc_nxt        = mc_r;
    mp_nxt        = mp_r;
    acc_nxt       = acc_r;
    a_nxt         = a_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    var_nxt       = var_r;
    x_nxt         = x_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;
    min_nxt       = min_r;
    med_nxt       = med_r;
    max_nxt       = max_r;
    mean_nxt      = mean_r;
    ov_nxt        = ov_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_LOAD: begin
        // Hand a finished result over, then clear the batch
        if (out_load) begin
          out_valid_nxt = 1'b1;
          done_nxt      = 1'b0;
          kept_nxt      = '0;
          sum_nxt       = '0;
          sq_nxt        = '0;
          drop_nxt      = 1'b0;
        end else if (in_acc) begin
          if (keep) begin
            kept_nxt = kept_r + CW'(1);
            sum_nxt  = sum_r + SUM_W'(in_sample);
            sq_nxt   = sq_r + SQ_W'(sq_prod);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = S_SCAN;
            cnt_nxt   = '0;
          end
        end
      end
      S_SCAN: begin
        // Read sorted values as they pass the head
        if (cnt_r == CT_W'(0))      min_nxt = head_val;
        if (cnt_r == CT_W'(med_idx)) med_nxt = head_val;
        if (cnt_r == CT_W'(kept_r - CW'(1))) begin
          max_nxt   = head_val;
          state_nxt = S_MULA;
          cnt_nxt   = '0;
          mc_nxt    = ACC_W'(sq_r);
          mp_nxt    = ACC_W'(kept_r);
          acc_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CT_W'(1);
        end
      end
      S_MULA, S_MULB: begin
        acc_nxt = mul_acc;
        mc_nxt  = mc_r << 1;
        mp_nxt  = mp_r >> 1;
        cnt_nxt = cnt_r + CT_W'(1);
        if (cnt_r == CT_W'(SUM_W-1)) begin
          cnt_nxt = '0;
          if (state_r == S_MULA) begin
            a_nxt     = mul_acc;
            mc_nxt    = ACC_W'(sum_r);
            mp_nxt    = ACC_W'(sum_r);
            acc_nxt   = '0;
            state_nxt = S_MULB;
          end else begin
            state_nxt = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        // Clamp a negative variance numerator to zero
        q_nxt     = (a_r > acc_r) ? (a_r - acc_r) : '0;
        rem_nxt   = '0;
        div_nxt   = nn;
        cnt_nxt   = '0;
        state_nxt = S_DIVV;
      end
      S_DIVV, S_DIVM: begin
        q_nxt   = dv_q;
        rem_nxt = dv_rem;
        cnt_nxt = cnt_r + CT_W'(1);
        if (cnt_r == CT_W'(ACC_W-1)) begin
          cnt_nxt = '0;
          if (state_r == S_DIVV) begin
            var_nxt   = dv_q;
            q_nxt     = ACC_W'(sum_r);
            rem_nxt   = '0;
            div_nxt   = NN_W'(kept_r);
            state_nxt = S_DIVM;
          end else begin
            mean_nxt  = dv_q;
            x_nxt     = var_r;
            res_nxt   = '0;
            bit_nxt   = ACC_W'(1) << (ACC_W-2);
            state_nxt = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        x_nxt   = sr_x;
        res_nxt = sr_res;
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + CT_W'(1);
        if (cnt_r == CT_W'(SQ_STEPS-1)) begin
          cnt_nxt   = '0;
          ov_nxt    = drop_r;
          n_nxt     = kept_r;
          done_nxt  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      done_r      <= 1'b0;
      kept_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      drop_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      kept_r      <= kept_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      drop_r      <= drop_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mc_r   <= mc_nxt;
    mp_r   <= mp_nxt;
    acc_r  <= acc_nxt;
    a_r    <= a_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    var_r  <= var_nxt;
    x_r    <= x_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    min_r  <= min_nxt;
    med_r  <= med_nxt;
    max_r  <= max_nxt;
    mean_r <= mean_nxt;
    ov_r   <= ov_nxt;
    n_r    <= n_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_min_r  <= OUT_W'(min_r);
      o_med_r  <= OUT_W'(med_r);
      o_max_r  <= OUT_W'(max_r);
      o_mean_r <= mean_r[OUT_W-1:0];
      o_std_r  <= res_r[OUT_W-1:0];
      o_cnt_r  <= CNT_W'(n_r);
      o_ov_r   <= ov_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_minimum  = o_min_r;
  assign out_median   = o_med_r;
  assign out_maximum  = o_max_r;
  assign out_mean     = o_mean_r;
  assign out_std_dev  = o_std_r;
  assign out_count    = o_cnt_r;
  assign out_overflow = o_ov_r;

  // Checks
  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= CW'(MAX_SAMPLES))
    else $error("kept count past capacity");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> (kept_r == CW'(MAX_SAMPLES)))
    else $error("drop flagged with room left");

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> !in_ready)
    else $error("input taken while batch closes");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(done_r))
    else $error("result shown without finished work");

endmodule
`default_nettype wire

// ----- hw/rtl/bos_cell.sv -----
// One cell of the sorting row: holds a value and a valid bit.
// Depends on bos_pkg for the control struct.
`default_nettype none
module bos_cell #(
  parameter int SAMPLE_WIDTH = bos_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  bos_pkg::bos_chain_ctrl_t     ctrl,
  input  wire [SAMPLE_WIDTH-1:0]       new_val,
  input  wire [SAMPLE_WIDTH-1:0]       left_val,
  input  wire                          left_vld,
  input  wire                          left_lt,
  input  wire [SAMPLE_WIDTH-1:0]       right_val,
  input  wire                          right_vld,
  output logic [SAMPLE_WIDTH-1:0]      val,
  output logic                         vld,
  output logic                         lt
);
  import bos_pkg::*;

  logic [SAMPLE_WIDTH-1:0] val_r, val_nxt;
  logic                    vld_r, vld_nxt;

  // New sample belongs at or before this cell (empty cells act as infinity)
  assign lt  = !vld_r || (new_val < val_r);
  assign val = val_r;
  assign vld = vld_r;

  // Clear, take the new sample or the left neighbor on insert, take the right one on shift, or hold
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    priority if (ctrl.clr) begin
      vld_nxt = 1'b0;
    end else if (ctrl.ins) begin
      if (lt) begin
        if (!left_lt) begin
          val_nxt = new_val;
          vld_nxt = 1'b1;
        end else begin
          val_nxt = left_val;
          vld_nxt = left_vld;
        end
      end
    end else if (ctrl.shift) begin
      val_nxt = right_val;
      vld_nxt = right_vld;
    end else begin
      // Hold
      val_nxt = val_r;
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bos_chain.sv -----
// Row of sorting cells; keeps the batch sorted as items arrive.
// Depends on bos_pkg and bos_cell.
`default_nettype none
module bos_chain #(
  parameter int MAX_SAMPLES  = bos_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_WIDTH = bos_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  bos_pkg::bos_chain_ctrl_t    ctrl,
  input  wire [SAMPLE_WIDTH-1:0]      new_val,
  output logic [SAMPLE_WIDTH-1:0]     head_val
);
  import bos_pkg::*;

  logic [SAMPLE_WIDTH-1:0] cval [MAX_SAMPLES];
  logic                    cvld [MAX_SAMPLES];
  logic                    clt  [MAX_SAMPLES];

  assign head_val = cval[0];

  // Link each cell to both neighbors; the ends see an empty neighbor
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic [SAMPLE_WIDTH-1:0] lval, rval;
    logic                    lvld, llt, rvld;
    if (i == 0) begin : g_head
      assign lval = '0;
      assign lvld = 1'b0;
      assign llt  = 1'b0;
    end else begin : g_mid
      assign lval = cval[i-1];
      assign lvld = cvld[i-1];
      assign llt  = clt[i-1];
    end
    if (i == MAX_SAMPLES-1) begin : g_tail
      assign rval = '0;
      assign rvld = 1'b0;
    end else begin : g_body
      assign rval = cval[i+1];
      assign rvld = cvld[i+1];
    end
    bos_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .new_val   (new_val),
      .left_val  (lval),
      .left_vld  (lvld),
      .left_lt   (llt),
      .right_val (rval),
      .right_vld (rvld),
      .val       (cval[i]),
      .vld       (cvld[i]),
      .lt        (clt[i])
    );
  end

endmodule
`default_nettype wire

// ----- bench/batch_order_statistics_top_test.sv -----
// Testbench for batch_order_statistics_top: drives batches of Q12.12 samples
// and checks min, median, max, mean, std_dev, count and overflow per batch.
// Depends on bos_pkg and the batch_order_statistics_top RTL.
`timescale 1ns / 1ps
`default_nettype none
module batch_order_statistics_top_test;
  import bos_pkg::*;

  localparam int NSAMP = MAX_SAMPLES_DEF;
  localparam int SW    = SAMPLE_WIDTH_DEF;

  typedef struct packed {
    logic [SW-1:0] sample;
    logic          last;
  } sample_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] minimum;
    logic [OUT_W-1:0] median;
    logic [OUT_W-1:0] maximum;
    logic [OUT_W-1:0] mean;
    logic [OUT_W-1:0] std_dev;
    logic [CNT_W-1:0] count;
    logic             overflow;
  } summary_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SW-1:0] in_sample = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUT_W-1:0] out_minimum, out_median, out_maximum, out_mean, out_std_dev;
  logic [CNT_W-1:0] out_count;
  logic out_overflow;

  sample_item_t pending_samples[$];
  summary_t     expected_summaries[$];
  bit           stim_done = 1'b0;
  bit           calm = 1'b0;
  bit           in_ready_seen = 1'b0;
  int           hold_off = 0;
  int           errors = 0;

  // batch state of the predictor
  logic [SW-1:0] batch_store[NSAMP];
  int            batch_count = 0;
  logic [63:0]   batch_sum = '0;
  logic [63:0]   batch_sq = '0;
  bit            batch_dropped = 1'b0;

  batch_order_statistics_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_minimum(out_minimum), .out_median(out_median), .out_maximum(out_maximum),
    .out_mean(out_mean), .out_std_dev(out_std_dev), .out_count(out_count),
    .out_overflow(out_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] root, bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Fold one accepted sample into the batch; close it out on last.
  task automatic accumulate_sample(input sample_item_t it);
    logic [SW-1:0] sorted[$];
    logic [63:0] n, a, b, variance;
    summary_t s;
    if (batch_count < NSAMP) begin
      batch_store[batch_count] = it.sample;
      batch_count++;
      batch_sum += it.sample;
      batch_sq += 64'(it.sample) * 64'(it.sample);
    end else begin
      batch_dropped = 1'b1;
    end
    if (it.last) begin
      for (int i = 0; i < batch_count; i++) sorted.push_back(batch_store[i]);
      sorted.sort();
      n = batch_count;
      a = n * batch_sq;
      b = batch_sum * batch_sum;
      variance = (a > b) ? (a - b) / (n * n) : 64'd0;
      s.minimum  = sorted[0];
      s.median   = sorted[(batch_count - 1) / 2];
      s.maximum  = sorted[batch_count - 1];
      s.mean     = OUT_W'(batch_sum / n);
      s.std_dev  = OUT_W'(int_sqrt(variance));
      s.count    = CNT_W'(n);
      s.overflow = batch_dropped;
      expected_summaries.push_back(s);
      batch_count = 0;
      batch_sum = '0;
      batch_sq = '0;
      batch_dropped = 1'b0;
    end
  endtask

  // Drive items at the falling edge; advance when the last one was taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
          in_sample <= pending_samples[0].sample;
          in_last   <= pending_samples[0].last;
          in_valid  <= 1'b1;
          void'(pending_samples.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off  <= hold_off - 1;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 19);
      end
    end
  end

  // Sample handshakes at the rising edge.
  always @(posedge clk) begin
    in_ready_seen <= 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_ready_seen <= 1'b1;
        accumulate_sample('{sample: in_sample, last: in_last});
      end
      if (out_valid && out_ready) begin
        if (expected_summaries.size() == 0) begin
          $display("%0t: unexpected result min=%h", $realtime, out_minimum);
          errors++;
        end else begin
          summary_t e, got;
          e = expected_summaries.pop_front();
          got = '{out_minimum, out_median, out_maximum, out_mean, out_std_dev,
                  out_count, out_overflow};
          if (got.minimum !== e.minimum)
            $display("%0t: minimum exp %h got %h", $realtime, e.minimum, got.minimum);
          if (got.median !== e.median)
            $display("%0t: median exp %h got %h", $realtime, e.median, got.median);
          if (got.maximum !== e.maximum)
            $display("%0t: maximum exp %h got %h", $realtime, e.maximum, got.maximum);
          if (got.mean !== e.mean)
            $display("%0t: mean exp %h got %h", $realtime, e.mean, got.mean);
          if (got.std_dev !== e.std_dev)
            $display("%0t: std_dev exp %h got %h", $realtime, e.std_dev, got.std_dev);
          if (got.count !== e.count)
            $display("%0t: count exp %0d got %0d", $realtime, e.count, got.count);
          if (got.overflow !== e.overflow)
            $display("%0t: overflow exp %b got %b", $realtime, e.overflow, got.overflow);
          if (got !== e) errors++;
        end
      end
    end
  end

  function automatic logic [SW-1:0] rand_sample();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return SW'($urandom_range(255));
      3: return ~SW'($urandom_range(255));
      default: return SW'($urandom);
    endcase
  endfunction

  // Queue one batch of the given length (length past capacity overflows).
  task automatic queue_batch(input int len, input bit fixed, input logic [SW-1:0] v);
    for (int i = 0; i < len; i++)
      pending_samples.push_back('{sample: fixed ? v : rand_sample(), last: i == len - 1});
  endtask

  initial begin
    int queued;
    int len;
    // directed: single samples at the extremes, short batches, full store, overflow
    queue_batch(1, 1, '0);
    queue_batch(1, 1, '1);
    queue_batch(2, 0, '0);
    queue_batch(3, 0, '0);
    pending_samples.push_back('{sample: '0, last: 1'b0});
    pending_samples.push_back('{sample: '1, last: 1'b1});
    queued = pending_samples.size();
    queue_batch(NSAMP, 1, '1);
    queue_batch(NSAMP + 3, 0, '0);
    queue_batch(NSAMP + 1, 1, 24'h000001);
    queued = pending_samples.size();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // random batches, mostly short, some at or over capacity
    while (queued < 1550) begin
      case ($urandom_range(9))
        0: len = NSAMP + $urandom_range(1, 6);
        1: len = NSAMP;
        default: len = $urandom_range(1, 12);
      endcase
      queue_batch(len, 0, '0);
      queued += len;
    end
    // let the output stall long enough to fill the pipe and back up the input
    repeat (50) @(posedge clk);
    hold_off = 2000;
    while (hold_off > 0) @(posedge clk);
    // stretch with no idling on either side
    calm = 1'b1;
    repeat (3000) @(posedge clk);
    calm = 1'b0;
    while (pending_samples.size() > 0 || in_valid) @(posedge clk);
    while (expected_summaries.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/bos_pkg.sv
hw/rtl/bos_cell.sv
hw/rtl/bos_chain.sv
hw/rtl/batch_order_statistics_top.sv
bench/batch_order_statistics_top_test.sv
